// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro expands to a concurrent
// assertion clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hw/rtl/ssnf_pkg.sv -----
`default_nettype none
package ssnf_pkg;

  localparam int DIGIT_COUNT_DEFAULT = 8;
  localparam int POS_W      = 3;
  localparam int SEG_W      = 8;
  localparam int VALUE_W    = 16;
  localparam int BCD_DIGITS = 5;
  localparam int HEX_DIGITS = 4;
  localparam int STEP_W     = 4;
  localparam int CNT_W      = 4;

  localparam logic [SEG_W-1:0] MINUS_PATTERN = 8'h40;
  localparam logic [SEG_W-1:0] SELECT_TOP    = 8'h80;

  typedef enum logic [1:0] {
    OP_UNSIGNED = 2'd0,
    OP_SIGNED   = 2'd1,
    OP_HEX      = 2'd2,
    OP_RAW      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DABBLE,
    ACT_SCAN,
    ACT_MINUS,
    ACT_DIGIT,
    ACT_RAW
  } action_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_IN,
    C_RAW,
    C_HEX,
    C_CNT_MORE,
    C_EMPTY,
    C_MINUS_WAIT,
    C_DIGIT_MORE,
    C_RAW_WAIT
  } cond_t;

  typedef struct packed {
    action_t           action;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic is_raw;
    logic is_hex;
    logic cnt_more;
    logic empty;
    logic neg;
    logic pos_ok;
    logic idx_zero;
  } status_t;

  typedef struct packed {
    logic             last;
    logic [SEG_W-1:0] segments;
    logic [SEG_W-1:0] select;
  } beat_t;

  // Step addresses of the control program.
  localparam logic [STEP_W-1:0] S_LOAD   = 4'd0;
  localparam logic [STEP_W-1:0] S_KIND   = 4'd1;
  localparam logic [STEP_W-1:0] S_BASE   = 4'd2;
  localparam logic [STEP_W-1:0] S_DABBLE = 4'd3;
  localparam logic [STEP_W-1:0] S_SCAN   = 4'd4;
  localparam logic [STEP_W-1:0] S_MINUS  = 4'd5;
  localparam logic [STEP_W-1:0] S_DIGIT  = 4'd6;
  localparam logic [STEP_W-1:0] S_END    = 4'd7;
  localparam logic [STEP_W-1:0] S_RAW    = 4'd8;
  localparam logic [STEP_W-1:0] S_RAWEND = 4'd9;
  localparam logic [STEP_W-1:0] S_LAST   = S_RAWEND;

  // Control store: jump to target when the condition holds, else fall through.
  function automatic ctl_word_t program_word(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    case (step)
      S_LOAD:   w = '{ACT_LOAD,   C_NO_IN,      S_LOAD};
      S_KIND:   w = '{ACT_NONE,   C_RAW,        S_RAW};
      S_BASE:   w = '{ACT_NONE,   C_HEX,        S_SCAN};
      S_DABBLE: w = '{ACT_DABBLE, C_CNT_MORE,   S_DABBLE};
      S_SCAN:   w = '{ACT_SCAN,   C_EMPTY,      S_LOAD};
      S_MINUS:  w = '{ACT_MINUS,  C_MINUS_WAIT, S_MINUS};
      S_DIGIT:  w = '{ACT_DIGIT,  C_DIGIT_MORE, S_DIGIT};
      S_END:    w = '{ACT_NONE,   C_ALWAYS,     S_LOAD};
      S_RAW:    w = '{ACT_RAW,    C_RAW_WAIT,   S_RAW};
      S_RAWEND: w = '{ACT_NONE,   C_ALWAYS,     S_LOAD};
      default:  w = '{ACT_NONE,   C_ALWAYS,     S_LOAD};
    endcase
    return w;
  endfunction

  // Common-cathode glyphs for 0-F, bit 0 is segment a.
  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
    logic [SEG_W-1:0] g;
    case (d)
      4'h0: g = 8'h3f;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5b;
      4'h3: g = 8'h4f;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6d;
      4'h6: g = 8'h7d;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7f;
      4'h9: g = 8'h6f;
      4'ha: g = 8'h77;
      4'hb: g = 8'h7c;
      4'hc: g = 8'h39;
      4'hd: g = 8'h5e;
      4'he: g = 8'h79;
      4'hf: g = 8'h71;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic logic [SEG_W-1:0] select_for(input logic [POS_W-1:0] pos);
    return ~(SELECT_TOP >> pos);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ssnf_datapath.sv -----
`default_nettype none
module ssnf_datapath #(
  parameter int DIGIT_COUNT = ssnf_pkg::DIGIT_COUNT_DEFAULT
) (
  input  wire                              clk,
  input  ssnf_pkg::action_t                action,
  input  wire                              accept,
  input  wire                              fire,
  input  wire  [1:0]                       operation,
  input  wire  [ssnf_pkg::VALUE_W-1:0]     value,
  input  wire                              full_width,
  input  wire  [ssnf_pkg::POS_W-1:0]       position,
  input  wire  [ssnf_pkg::SEG_W-1:0]       pattern,
  output ssnf_pkg::status_t                status,
  output ssnf_pkg::beat_t                  beat
);

  localparam int IW = $clog2(DIGIT_COUNT);
  localparam int NW = $clog2(DIGIT_COUNT + 1);
  localparam int BCD_W = 4 * ssnf_pkg::BCD_DIGITS;

  ssnf_pkg::op_t                  op;
  logic                           full;
  logic                           neg;
  logic [ssnf_pkg::POS_W-1:0]     pos;
  logic [ssnf_pkg::SEG_W-1:0]     pat;
  logic [ssnf_pkg::VALUE_W-1:0]   bin;
  logic [BCD_W-1:0]               bcd;
  logic [BCD_W-1:0]               bcd_adj;
  logic [ssnf_pkg::CNT_W-1:0]     cnt;
  logic [IW-1:0]                  idx;
  logic [3:0]                     digit [DIGIT_COUNT];
  logic [NW-1:0]                  n;
  logic [3:0]                     cur_digit;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int d = 0; d < ssnf_pkg::BCD_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
  end

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
    logic [3:0] hex_d;
    logic [3:0] dec_d;
    if (i < ssnf_pkg::HEX_DIGITS) begin : g_hex
      assign hex_d = bin[4*i +: 4];
    end else begin : g_hex_zero
      assign hex_d = 4'd0;
    end
    if (i < ssnf_pkg::BCD_DIGITS) begin : g_dec
      assign dec_d = bcd[4*i +: 4];
    end else begin : g_dec_zero
      assign dec_d = 4'd0;
    end
    assign digit[i] = (op == ssnf_pkg::OP_HEX) ? hex_d : dec_d;
  end

  // Count of digits to show: highest nonzero digit, or all of them.
  always_comb begin
    n = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (digit[i] != 4'd0) n = NW'(i + 1);
    end
    if (full) n = NW'(DIGIT_COUNT);
  end

  assign cur_digit = digit[idx];

  always_ff @(posedge clk) begin
    case (action)
      ssnf_pkg::ACT_LOAD: begin
        if (accept) begin
          op   <= ssnf_pkg::op_t'(operation);
          full <= full_width && (operation != ssnf_pkg::OP_SIGNED);
          neg  <= (operation == ssnf_pkg::OP_SIGNED) && value[ssnf_pkg::VALUE_W-1];
          bin  <= ((operation == ssnf_pkg::OP_SIGNED) && value[ssnf_pkg::VALUE_W-1])
                  ? (~value + 16'd1) : value;
          pos  <= position;
          pat  <= pattern;
          bcd  <= '0;
          cnt  <= '0;
        end
      end
      ssnf_pkg::ACT_DABBLE: begin
        bcd <= {bcd_adj[BCD_W-2:0], bin[ssnf_pkg::VALUE_W-1]};
        bin <= {bin[ssnf_pkg::VALUE_W-2:0], 1'b0};
        cnt <= cnt + 4'd1;
      end
      ssnf_pkg::ACT_SCAN: begin
        idx <= IW'(n - NW'(1));
      end
      ssnf_pkg::ACT_DIGIT: begin
        if (fire) idx <= idx - IW'(1);
      end
      default: begin
      end
    endcase
  end

  assign status.is_raw   = (op == ssnf_pkg::OP_RAW);
  assign status.is_hex   = (op == ssnf_pkg::OP_HEX);
  assign status.cnt_more = (cnt != {ssnf_pkg::CNT_W{1'b1}});
  assign status.empty    = (n == '0);
  assign status.neg      = neg;
  assign status.pos_ok   = ({1'b0, pos} < (ssnf_pkg::POS_W + 1)'(DIGIT_COUNT));
  assign status.idx_zero = (idx == '0);

  always_comb begin
    case (action)
      ssnf_pkg::ACT_MINUS: begin
        beat.select   = ssnf_pkg::select_for(ssnf_pkg::POS_W'(idx) + ssnf_pkg::POS_W'(1));
        beat.segments = ssnf_pkg::MINUS_PATTERN;
        beat.last     = 1'b0;
      end
      ssnf_pkg::ACT_RAW: begin
        beat.select   = ssnf_pkg::select_for(pos);
        beat.segments = pat;
        beat.last     = 1'b1;
      end
      default: begin
        beat.select   = ssnf_pkg::select_for(ssnf_pkg::POS_W'(idx));
        beat.segments = ssnf_pkg::glyph(cur_digit);
        beat.last     = (idx == '0);
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/seven_segment_number_formatter_unit.sv -----
`default_nettype none
// Channel | Dir | Beat contents
// s_*     | in  | tuser: operation[1:0]; tdata: value, full_width, position, pattern
// m_*     | out | tdata: digit_select, segments; tlast: final write of a run
//
// A decimal item runs 16 double-dabble shifts before its digits are written (the
// minus sign has its own step); hex skips the conversion, a raw pattern gives at
// most one write, and a suppressed decimal or hex zero writes nothing; the next
// item waits for the whole run.
// rst is synchronous: it returns the step counter to the load step and empties
// the output register. A stalled m_tready holds the sequencer on its emit step.
`include "assert_macros.svh"
module seven_segment_number_formatter_unit #(
  parameter int DIGIT_COUNT = ssnf_pkg::DIGIT_COUNT_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // value[15:0], full_width[16], position[19:17],
                                 // pattern[27:20], zero[31:28]
  input  wire  [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // digit_select[7:0], segments[15:8]
  output logic        m_tlast
);

  logic [ssnf_pkg::STEP_W-1:0] step;
  ssnf_pkg::ctl_word_t         cw;
  ssnf_pkg::status_t           st;
  ssnf_pkg::beat_t             beat;
  logic                        accept;
  logic                        busy;
  logic                        fire;
  logic                        take_jump;

  // Fetch the control word for the current step.
  assign cw = ssnf_pkg::program_word(step);

  assign s_tready = (cw.action == ssnf_pkg::ACT_LOAD);
  assign accept   = s_tvalid && s_tready;

  // Output register is busy while it holds a beat that is not taken now.
  assign busy = m_tvalid && !m_tready;

  // Fire on emit steps if not busy; minus if negative, raw if in range.
  always_comb begin
    case (cw.action)
      ssnf_pkg::ACT_MINUS: fire = !busy && st.neg;
      ssnf_pkg::ACT_DIGIT: fire = !busy;
      ssnf_pkg::ACT_RAW:   fire = !busy && st.pos_ok;
      default:             fire = 1'b0;
    endcase
  end

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (cw.cond)
      ssnf_pkg::C_ALWAYS:     take_jump = 1'b1;
      ssnf_pkg::C_NO_IN:      take_jump = !s_tvalid;
      ssnf_pkg::C_RAW:        take_jump = st.is_raw;
      ssnf_pkg::C_HEX:        take_jump = st.is_hex;
      ssnf_pkg::C_CNT_MORE:   take_jump = st.cnt_more;
      ssnf_pkg::C_EMPTY:      take_jump = st.empty;
      ssnf_pkg::C_MINUS_WAIT: take_jump = st.neg && busy;
      ssnf_pkg::C_DIGIT_MORE: take_jump = busy || !st.idx_zero;
      ssnf_pkg::C_RAW_WAIT:   take_jump = st.pos_ok && busy;
      default:                take_jump = 1'b0;
    endcase
  end

  // Advance the step counter: jump on a true condition, else fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ssnf_pkg::S_LOAD;
    end else if (take_jump) begin
      step <= cw.target;
    end else begin
      step <= step + ssnf_pkg::STEP_W'(1);
    end
  end

  ssnf_datapath #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_datapath (
    .clk        (clk),
    .action     (cw.action),
    .accept     (accept),
    .fire       (fire),
    .operation  (s_tuser),
    .value      (s_tdata[15:0]),
    .full_width (s_tdata[16]),
    .position   (s_tdata[19:17]),
    .pattern    (s_tdata[27:20]),
    .status     (st),
    .beat       (beat)
  );

  // Output register: load a fresh beat on fire, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {beat.segments, beat.select};
      m_tlast <= beat.last;
    end
  end

  // The step counter stays inside the program.
  `ASSERT_NEVER(a_step_range, step > ssnf_pkg::S_LAST, "step counter left the program")
  // A pending non-final write means its run is still being issued.
  `ASSERT_ALWAYS(a_run_open, (m_tvalid && !m_tlast) |-> !s_tready, "input taken mid-run")
  // Never overwrite a beat that is still waiting.
  `ASSERT_NEVER(a_no_overwrite, fire && busy, "output beat overwritten")

endmodule
`default_nettype wire

// ----- dv/tb_seven_segment_number_formatter_unit.sv -----
module tb_seven_segment_number_formatter_unit;

  localparam int NUM_DIGITS   = ssnf_pkg::DIGIT_COUNT_DEFAULT;
  localparam int RANDOM_REQS  = 107;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  // Common-cathode glyphs, digit d sits at bits [8*d +: 8].
  localparam logic [16*ssnf_pkg::SEG_W-1:0] DIGIT_GLYPHS = {
    8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f, 8'h7f,
    8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  typedef struct {
    ssnf_pkg::op_t op;
    logic [15:0]   value;
    logic          full_width;
    logic [2:0]    position;
    logic [7:0]    pattern;
  } format_req_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // value[15:0], full_width[16], position[19:17],
                               // pattern[27:20], zero[31:28]
  logic [1:0]  s_tuser = '0;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // digit_select[7:0], segments[15:8]
  logic        m_tlast;

  format_req_t       pending_reqs[$];
  ssnf_pkg::beat_t   expected_writes[$];
  format_req_t       in_flight;
  int          reqs_total = 0;
  int          reqs_accepted = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          stall_mode_left = 0;

  seven_segment_number_formatter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expand one request into the digit writes it should produce, most
  // significant position first, and append them to the expected stream.
  function automatic void queue_digit_writes(format_req_t r);
    logic [3:0]                 digs[NUM_DIGITS];
    logic [2:0]                 wr_pos[NUM_DIGITS + 1];
    logic [ssnf_pkg::SEG_W-1:0] wr_seg[NUM_DIGITS + 1];
    logic [16:0]      mag;
    int               base;
    int               n;
    int               k;
    logic             negative;
    logic             keep_zeros;
    n = 0;
    k = 0;
    negative = 1'b0;
    if (r.op == ssnf_pkg::OP_RAW) begin
      // Out-of-range positions only exist for narrower displays.
      if (r.position < NUM_DIGITS) begin
        wr_pos[0] = r.position;
        wr_seg[0] = r.pattern;
        k = 1;
      end
    end else begin
      base = (r.op == ssnf_pkg::OP_HEX) ? 16 : 10;
      if (r.op == ssnf_pkg::OP_SIGNED) begin
        // Show the magnitude; full width does not apply to signed.
        negative   = r.value[15];
        mag        = negative ? (17'h10000 - {1'b0, r.value}) : {1'b0, r.value};
        keep_zeros = 1'b0;
      end else begin
        mag        = {1'b0, r.value};
        keep_zeros = r.full_width;
      end
      while (n < NUM_DIGITS && (keep_zeros || mag != 0)) begin
        digs[n] = 4'(mag % base);
        mag     = mag / base;
        n++;
      end
      // Minus sign goes just above the highest digit.
      if (negative && n < NUM_DIGITS) begin
        wr_pos[k] = 3'(n);
        wr_seg[k] = ssnf_pkg::MINUS_PATTERN;
        k++;
      end
      for (int i = n - 1; i >= 0; i--) begin
        wr_pos[k] = 3'(i);
        wr_seg[k] = DIGIT_GLYPHS[digs[i]*8 +: 8];
        k++;
      end
    end
    for (int j = 0; j < k; j++)
      expected_writes.push_back('{last: (j == k - 1), segments: wr_seg[j],
                                  select: ~(8'h80 >> wr_pos[j])});
  endfunction

  function automatic void add_req(ssnf_pkg::op_t op, logic [15:0] value,
                                  logic full_width, logic [2:0] position,
                                  logic [7:0] pattern);
    pending_reqs.push_back('{op, value, full_width, position, pattern});
    reqs_total++;
  endfunction

  // Bias values toward short numbers and digit-count boundaries.
  function automatic logic [15:0] pick_value();
    logic [15:0] corners[13] = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100,
                                 16'd9999, 16'd10000, 16'h7fff, 16'h8000,
                                 16'h8001, 16'hfff0, 16'hffff};
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 15));
      1: return 16'($urandom_range(0, 999));
      2: return corners[$urandom_range(0, 12)];
      3: return 16'(1 << $urandom_range(0, 15)) ^ 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Fill the request queue: directed corners first, then random requests.
  initial begin
    // Unsigned: zero with and without full width, extremes, digit rollover.
    add_req(ssnf_pkg::OP_UNSIGNED, 16'd0,     1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_UNSIGNED, 16'd0,     1'b1, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_UNSIGNED, 16'hffff,  1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_UNSIGNED, 16'hffff,  1'b1, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_UNSIGNED, 16'd1,     1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_UNSIGNED, 16'd10,    1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_UNSIGNED, 16'd20406, 1'b1, 3'($urandom), 8'($urandom));
    // Signed: zero, most negative, -1, most positive, full width ignored.
    add_req(ssnf_pkg::OP_SIGNED,   16'd0,     1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_SIGNED,   16'd0,     1'b1, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_SIGNED,   16'h8000,  1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_SIGNED,   16'hffff,  1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_SIGNED,   16'h7fff,  1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_SIGNED,   16'h7fff,  1'b1, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_SIGNED,   16'hff9c,  1'b1, 3'($urandom), 8'($urandom));
    // Hex: zero both ways, all-F, every letter glyph.
    add_req(ssnf_pkg::OP_HEX,      16'd0,     1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_HEX,      16'd0,     1'b1, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_HEX,      16'hffff,  1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_HEX,      16'hffff,  1'b1, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_HEX,      16'habcd,  1'b0, 3'($urandom), 8'($urandom));
    add_req(ssnf_pkg::OP_HEX,      16'h00e9,  1'b1, 3'($urandom), 8'($urandom));
    // Raw: both end positions, blank and full patterns, dot only.
    add_req(ssnf_pkg::OP_RAW,      16'($urandom), 1'b1, 3'd0, 8'h00);
    add_req(ssnf_pkg::OP_RAW,      16'($urandom), 1'b0, 3'd7, 8'hff);
    add_req(ssnf_pkg::OP_RAW,      16'($urandom), 1'b1, 3'd3, 8'h80);
    for (int i = 0; i < RANDOM_REQS; i++)
      add_req(ssnf_pkg::op_t'($urandom_range(0, 3)), pick_value(), 1'($urandom),
              3'($urandom), 8'($urandom));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken, then for the display run to drain.
    while (reqs_accepted != reqs_total) @(negedge clk);
    while (expected_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Sender: predict on acceptance, then present the next request unless a
  // gap is running. Bursts of random length alternate with random gaps.
  always @(posedge clk) begin
    logic hold;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      hold = s_tvalid;
      if (s_tvalid && s_tready) begin
        queue_digit_writes(in_flight);
        reqs_accepted++;
        hold = 1'b0;
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          in_flight = pending_reqs.pop_front();
          s_tdata  <= {4'b0, in_flight.pattern, in_flight.position,
                       in_flight.full_width, in_flight.value};
          s_tuser  <= in_flight.op;
          hold = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            case ($urandom_range(0, 2))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 6);
              default: gap_left = $urandom_range(7, 40);
            endcase
          end
        end
      end
      s_tvalid <= hold;
    end
  end

  // Receiver: switch at random between always ready, coin-flip, periodic and heavy
  // stall patterns.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(16, 96);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom);
        2: m_tready <= (cycle_count % 5) != 0;
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check every accepted beat against the oldest outstanding write.
  always @(posedge clk) begin
    ssnf_pkg::beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected beat: digit_select %02h segments %02h last %0b",
               m_tdata[7:0], m_tdata[15:8], m_tlast);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        if (m_tdata[7:0] !== want.select) begin
          $error("digit_select: expected %02h, got %02h", want.select, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[15:8] !== want.segments) begin
          $error("segments: expected %02h, got %02h", want.segments, m_tdata[15:8]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
